/* rtl/iso8583_field_parser_macros.svh */
// Assertion macros shared by the field parser RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ISO8583_FIELD_PARSER_MACROS_SVH
`define ISO8583_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ISO8583_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define ISO8583_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/iso8583_pkg.sv */
// Shared types, codes and the field table of the ISO 8583 field parser.
// No dependencies.
`default_nettype none

package iso8583_pkg;

	localparam int         MAX_FIELDS_DEF = 128;
	localparam logic [9:0] MAX_VAR_LEN    = 10'd999;

	// Field formats
	localparam logic [2:0] FK_N       = 3'd0;
	localparam logic [2:0] FK_N_LL    = 3'd1;
	localparam logic [2:0] FK_N_LLL   = 3'd2;
	localparam logic [2:0] FK_ANS     = 3'd3;
	localparam logic [2:0] FK_ANS_LLL = 3'd4;
	localparam logic [2:0] FK_B       = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_TYPE  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic       defined;
		logic [2:0] kind;
		logic [9:0] len;
	} fdef_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] type_value;
		logic [7:0]  field_number;
		logic [7:0]  char_high;
		logic [7:0]  char_low;
		logic [1:0]  char_count;
		logic        field_end;
		logic        message_end;
	} result_t;

	typedef struct packed {
		logic [7:0] field_number;
		logic       rest_empty;
	} pick_t;

	// Fixed data element table: format and length (digits, bytes or bits)
	function automatic fdef_t field_lookup(input logic [7:0] f);
		fdef_t d;
		begin
			case (f)
				8'd1:    d = '{1'b1, FK_B,       10'd64};
				8'd2:    d = '{1'b1, FK_N_LL,    10'd19};
				8'd3:    d = '{1'b1, FK_N,       10'd6};
				8'd4:    d = '{1'b1, FK_N,       10'd12};
				8'd7:    d = '{1'b1, FK_N,       10'd10};
				8'd11:   d = '{1'b1, FK_N,       10'd6};
				8'd22:   d = '{1'b1, FK_N,       10'd3};
				8'd41:   d = '{1'b1, FK_ANS,     10'd8};
				8'd60:   d = '{1'b1, FK_ANS_LLL, 10'd999};
				8'd70:   d = '{1'b1, FK_N,       10'd3};
				default: d = '{1'b0, FK_N,       10'd0};
			endcase
			return d;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/iso8583_pick.sv */
// Next-field picker: priority encoder over the pending field bitmap.
// Depends on iso8583_pkg.
`default_nettype none

module iso8583_pick #(
	parameter int MAX_FIELDS = iso8583_pkg::MAX_FIELDS_DEF
) (
	input  wire logic [MAX_FIELDS-1:0] bitmap,
	output logic [MAX_FIELDS-1:0]      rest,
	output iso8583_pkg::pick_t         pick
);
	import iso8583_pkg::*;

	logic [MAX_FIELDS-1:0] lowest;
	logic [7:0]            first_num;

	// Find the lowest pending field, numbered from one
	always_comb begin
		first_num = '0;
		for (int i = MAX_FIELDS - 1; i >= 0; i--) begin
			if (bitmap[i]) begin
				first_num = 8'(i + 1);
			end
		end
	end

	// Drop the picked field and tell whether any remain
	assign lowest = bitmap & (~bitmap + {{(MAX_FIELDS-1){1'b0}}, 1'b1});
	assign rest   = bitmap & ~lowest;
	assign pick   = '{field_number: first_num, rest_empty: (rest == '0)};

endmodule

`default_nettype wire

/* rtl/iso8583_outbuf.sv */
// Result register with one skid entry between the parser and the output stream.
// Depends on iso8583_pkg and the assertion macro header.
`default_nettype none
`include "iso8583_field_parser_macros.svh"

module iso8583_outbuf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire iso8583_pkg::result_t push_data,
	output logic                      room,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output iso8583_pkg::result_t      out_data
);
	import iso8583_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Control: main entry first, skid only while main stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (main_valid_q) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			main_valid_q <= push;
		end
	end

	// Payload: move skid forward on a drain, else load the new beat
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_valid_q)) begin
			main_q <= push_data;
		end
		if (push && main_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	`ISO8583_ASSERT_IMP(a_skid_needs_main, skid_valid_q, main_valid_q, "skid full, main empty")
	`ISO8583_ASSERT_IMP(a_push_has_room, push, !skid_valid_q, "push with no room")
	`ISO8583_ASSERT_NXT(a_skid_moves_up, pop && skid_valid_q, main_valid_q && !skid_valid_q,
		"skid beat lost on drain")

endmodule

`default_nettype wire

/* rtl/iso8583_field_parser.sv */
// Top level of the ISO 8583 field parser: input register, parse logic, result buffer.
// Depends on iso8583_pkg, iso8583_pick, iso8583_outbuf and the macro header.
//
//  channel | dir | tdata                | tuser          | tlast
//  s_      | in  | msg_byte             | first_byte     | -
//  m_      | out | type_value .. f_end  | kind           | message_end
//
// One byte per cycle while the output does not stall: a byte is held in the input register,
// the parse logic (field pick, table, length digits) works on it combinationally, and
// its result, if any, is registered in the result buffer.
// Reset clears the parser to idle and empties both registers; no clearing pass.
// While the output stalls one extra result fits in the skid entry; after that
// s_tready drops until the output drains.
`default_nettype none
`include "iso8583_field_parser_macros.svh"

module iso8583_field_parser #(
	parameter int MAX_FIELDS = iso8583_pkg::MAX_FIELDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
	input  wire logic [0:0]  s_tuser,   // [0] first_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [13:0] type_value, [21:14] field_number, [29:22] char_high,
	// [37:30] char_low, [39:38] char_count, [40] field_end, [47:41] zero
	output logic [47:0]      m_tdata,
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // message_end
);
	import iso8583_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_BITMAP = 3'd2;
	localparam logic [2:0] PH_SELECT = 3'd3;
	localparam logic [2:0] PH_LENGTH = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// Parser state
	logic [2:0]            phase_q;
	logic [4:0]            hc_q;
	logic [13:0]           ta_q;
	logic [MAX_FIELDS-1:0] bm_q;
	logic [7:0]            cf_q;
	logic [2:0]            fk_q;
	logic [9:0]            bl_q;
	logic [9:0]            la_q;
	logic [1:0]            lds_q;

	logic [2:0]            phase_d;
	logic [4:0]            hc_d;
	logic [13:0]           ta_d;
	logic [MAX_FIELDS-1:0] bm_d;
	logic [7:0]            cf_d;
	logic [2:0]            fk_d;
	logic [9:0]            bl_d;
	logic [9:0]            la_d;
	logic [1:0]            lds_d;

	logic                  room;
	logic                  adv;
	logic                  res_v;
	result_t               res;
	result_t               out_res;
	logic [MAX_FIELDS-1:0] rest;
	pick_t                 pick;

	function automatic logic [13:0] type_digit(input logic [13:0] acc, input logic [3:0] nib);
		return (acc << 3) + (acc << 1) + {10'd0, nib};
	endfunction

	function automatic logic [9:0] sat_digit(input logic [9:0] acc, input logic [3:0] nib);
		logic [13:0] v;
		begin
			v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {10'd0, nib};
			return (v > 14'd1023) ? 10'd1023 : v[9:0];
		end
	endfunction

	// Input handshake: take a beat whenever the result side has room
	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
		end
	end

	iso8583_pick #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_pick (
		.bitmap(bm_q),
		.rest  (rest),
		.pick  (pick)
	);

	// Parse one byte
	always_comb begin
		logic [2:0]            ph_e;
		logic [4:0]            hc_n;
		logic [13:0]           ta1;
		logic [MAX_FIELDS-1:0] bm_set;
		logic [7:0]            cur_field;
		fdef_t                 cur_def;
		logic [2:0]            cur_kind;
		logic [9:0]            cur_bl;
		logic [9:0]            cur_la;
		logic [1:0]            cur_lds;
		logic                  cur_empty;
		logic                  run_len;
		logic                  run_data;
		logic                  numeric;
		logic [9:0]            limit;
		logic [9:0]            la1;
		logic [9:0]            la2;
		logic [1:0]            lds_n;
		logic [1:0]            need;
		logic [9:0]            bl_v;
		logic [9:0]            bl_n;
		logic [7:0]            ch;
		logic [7:0]            cl;
		logic [1:0]            cnt;

		ph_e    = first_s1 ? PH_TYPE : phase_q;
		phase_d = ph_e;
		hc_d    = first_s1 ? 5'd0 : hc_q;
		ta_d    = first_s1 ? 14'd0 : ta_q;
		bm_d    = first_s1 ? '0 : bm_q;
		cf_d    = cf_q;
		fk_d    = fk_q;
		bl_d    = bl_q;
		la_d    = la_q;
		lds_d   = lds_q;
		res_v   = 1'b0;
		res     = '0;

		hc_n = 5'd0;
		ta1  = 14'd0;
		bm_set = bm_q;

		// Field context: fresh from the table on a select, else held
		cur_field = (ph_e == PH_SELECT) ? pick.field_number : cf_q;
		cur_def   = field_lookup(cur_field);
		cur_kind  = fk_q;
		cur_bl    = bl_q;
		cur_la    = la_q;
		cur_lds   = lds_q;
		cur_empty = (bm_q == '0);
		run_len   = 1'b0;
		run_data  = 1'b0;

		case (ph_e)
			PH_TYPE: begin
				ta1  = type_digit(hc_d == 5'd0 && first_s1 ? 14'd0 : ta_d, byte_s1[7:4]);
				ta_d = type_digit(ta1, byte_s1[3:0]);
				hc_n = hc_d + 5'd1;
				hc_d = hc_n;
				if (hc_n >= 5'd2) begin
					res_v          = 1'b1;
					res.kind       = KIND_TYPE;
					res.type_value = ta_d;
					hc_d           = 5'd0;
					phase_d        = PH_BITMAP;
				end
			end
			PH_BITMAP: begin
				for (int k = 0; k < MAX_FIELDS; k++) begin
					if (hc_q[3:0] == 4'(k >> 3) && byte_s1[7 - (k & 7)]) begin
						bm_set[k] = 1'b1;
					end
				end
				hc_n = hc_q + 5'd1;
				hc_d = hc_n;
				bm_d = bm_set;
				if (!((hc_n == 5'd8 && bm_set[0]) || hc_n < 5'd8 ||
						(hc_n > 5'd8 && hc_n < 5'd16))) begin
					bm_d[0] = 1'b0;
					phase_d = (bm_d == '0) ? PH_DONE : PH_SELECT;
				end
			end
			PH_SELECT: begin
				cf_d      = pick.field_number;
				bm_d      = rest;
				cur_empty = pick.rest_empty;
				if (!cur_def.defined) begin
					res_v            = 1'b1;
					res.kind         = KIND_ERROR;
					res.field_number = cur_field;
					res.field_end    = 1'b1;
					res.message_end  = 1'b1;
					phase_d          = PH_DONE;
				end else begin
					cur_kind = cur_def.kind;
					fk_d     = cur_def.kind;
					cur_la   = 10'd0;
					cur_lds  = 2'd0;
					la_d     = 10'd0;
					lds_d    = 2'd0;
					if (cur_def.kind == FK_N_LL || cur_def.kind == FK_N_LLL ||
							cur_def.kind == FK_ANS_LLL) begin
						run_len = 1'b1;
					end else begin
						run_data = 1'b1;
						case (cur_def.kind)
							FK_N:    cur_bl = 10'(({1'b0, cur_def.len} + 11'd1) >> 1);
							FK_B:    cur_bl = cur_def.len >> 3;
							default: cur_bl = cur_def.len;
						endcase
					end
				end
			end
			PH_LENGTH: run_len  = 1'b1;
			PH_DATA:   run_data = 1'b1;
			default: begin
			end
		endcase

		// Length digits: accumulate, then check and size the field
		la1   = sat_digit(cur_la, byte_s1[7:4]);
		la2   = sat_digit(la1, byte_s1[3:0]);
		lds_n = cur_lds + 2'd1;
		need  = (cur_kind == FK_N_LL) ? 2'd1 : 2'd2;
		limit = (cur_def.len < MAX_VAR_LEN) ? cur_def.len : MAX_VAR_LEN;
		bl_v  = (cur_kind == FK_ANS_LLL) ? la2 : 10'(({1'b0, la2} + 11'd1) >> 1);

		// Data byte: two ASCII digits for numeric formats, else raw
		numeric = (cur_kind == FK_N) || (cur_kind == FK_N_LL) || (cur_kind == FK_N_LLL);
		ch      = numeric ? (8'h30 + {4'd0, byte_s1[7:4]}) : byte_s1;
		cl      = numeric ? (8'h30 + {4'd0, byte_s1[3:0]}) : 8'd0;
		cnt     = numeric ? 2'd2 : 2'd1;
		bl_n    = cur_bl - 10'd1;

		if (run_len) begin
			la_d    = la2;
			lds_d   = lds_n;
			phase_d = PH_LENGTH;
			if (lds_n >= need) begin
				if (la2 > limit) begin
					res_v            = 1'b1;
					res.kind         = KIND_ERROR;
					res.field_number = cur_field;
					res.field_end    = 1'b1;
					res.message_end  = 1'b1;
					phase_d          = PH_DONE;
				end else begin
					bl_d = bl_v;
					if (bl_v == 10'd0) begin
						res_v            = 1'b1;
						res.kind         = KIND_DATA;
						res.field_number = cur_field;
						res.field_end    = 1'b1;
						res.message_end  = cur_empty;
						phase_d          = cur_empty ? PH_DONE : PH_SELECT;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
		end

		if (run_data) begin
			bl_d             = bl_n;
			res_v            = 1'b1;
			res.kind         = KIND_DATA;
			res.field_number = cur_field;
			res.char_high    = ch;
			res.char_low     = cl;
			res.char_count   = cnt;
			phase_d          = PH_DATA;
			if (bl_n == 10'd0) begin
				res.field_end   = 1'b1;
				res.message_end = cur_empty;
				phase_d         = cur_empty ? PH_DONE : PH_SELECT;
			end
		end
	end

	// Commit state on every taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hc_q    <= '0;
			ta_q    <= '0;
			bm_q    <= '0;
			cf_q    <= '0;
			fk_q    <= '0;
			bl_q    <= '0;
			la_q    <= '0;
			lds_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			ta_q    <= ta_d;
			bm_q    <= bm_d;
			cf_q    <= cf_d;
			fk_q    <= fk_d;
			bl_q    <= bl_d;
			la_q    <= la_d;
			lds_q   <= lds_d;
		end
	end

	iso8583_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv && res_v),
		.push_data(res),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	// Pack the result beat
	assign m_tdata = {7'd0, out_res.field_end, out_res.char_count, out_res.char_low,
		out_res.char_high, out_res.field_number, out_res.type_value};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.message_end;

	`ISO8583_ASSERT_IMP(a_error_ends_all, m_tvalid && m_tuser == KIND_ERROR,
		m_tdata[40] && m_tlast, "error beat without end flags")
	`ISO8583_ASSERT_IMP(a_data_has_bytes, phase_q == PH_DATA, bl_q != 10'd0,
		"data phase with nothing left")
	`ISO8583_ASSERT_IMP(a_length_is_var, phase_q == PH_LENGTH,
		fk_q == FK_N_LL || fk_q == FK_N_LLL || fk_q == FK_ANS_LLL,
		"length phase on a fixed field")

endmodule

`default_nettype wire
